// File: hw/rtl/pmsfp_pkg.sv
package pmsfp_pkg;

  // Frame layout.
  localparam int FRAME_BYTES   = 32;
  localparam int NUM_READINGS  = 12;
  localparam int POS_W         = 5;
  localparam int CH_W          = 4;

  localparam logic [7:0] START_FIRST  = 8'h42;
  localparam logic [7:0] START_SECOND = 8'h4D;

  // Byte positions inside a frame.
  localparam logic [POS_W-1:0] POS_AFTER_START = POS_W'(2);
  localparam logic [POS_W-1:0] POS_READ_FIRST  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_READ_END    = POS_W'(4 + 2 * NUM_READINGS);
  localparam logic [POS_W-1:0] POS_VERSION     = POS_W'(FRAME_BYTES - 4);
  localparam logic [POS_W-1:0] POS_ERROR       = POS_W'(FRAME_BYTES - 3);
  localparam logic [POS_W-1:0] POS_CKS_HI      = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CKS_LO      = POS_W'(FRAME_BYTES - 1);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_READINGS - 1);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef logic [NUM_READINGS-1:0][15:0] readings_t;

  // Status from the parser to the result sequencer.
  typedef struct packed {
    logic       done;       // last byte of a frame accepted this cycle
    logic [7:0] version;
    logic [7:0] error;
    logic       cks_ok;
    logic       end_next;   // the next byte will complete a frame
  } frame_stat_t;

endpackage

// File: hw/rtl/pmsfp_parser.sv
module pmsfp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_fire,
  input  logic [7:0]           rx_byte,
  output pmsfp_pkg::readings_t readings,
  output pmsfp_pkg::frame_stat_t stat
);
  import pmsfp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       version_r, version_nxt;
  logic [7:0]       error_r, error_nxt;
  logic             rd_we;
  logic [CH_W-1:0]  rd_idx;
  logic             done;
  readings_t        readings_r;

  // Sync hunt and byte collection.
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    hi_nxt      = hi_r;
    version_nxt = version_r;
    error_nxt   = error_r;
    rd_we       = 1'b0;
    rd_idx      = pos_r[POS_W-1:1] - CH_W'(POS_READ_FIRST >> 1);
    done        = 1'b0;
    if (byte_fire) begin
      case (phase_r)
        PH_SECOND: begin
          if (rx_byte == START_SECOND) begin
            phase_nxt = PH_BODY;
            pos_nxt   = POS_AFTER_START;
            sum_nxt   = 16'({8'd0, START_FIRST} + {8'd0, START_SECOND});
          end else if (rx_byte != START_FIRST) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (pos_r < POS_CKS_HI) begin
            sum_nxt = sum_r + {8'd0, rx_byte};
          end
          if (pos_r >= POS_READ_FIRST && pos_r < POS_READ_END) begin
            if (!pos_r[0]) begin
              hi_nxt = rx_byte;
            end else begin
              rd_we = 1'b1;
            end
          end else if (pos_r == POS_VERSION) begin
            version_nxt = rx_byte;
          end else if (pos_r == POS_ERROR) begin
            error_nxt = rx_byte;
          end else if (pos_r == POS_CKS_HI) begin
            hi_nxt = rx_byte;
          end
          if (pos_r == POS_CKS_LO) begin
            done      = 1'b1;
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: begin
          phase_nxt = (rx_byte == START_FIRST) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      pos_r     <= '0;
      sum_r     <= '0;
      hi_r      <= '0;
      version_r <= '0;
      error_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      hi_r      <= hi_nxt;
      version_r <= version_nxt;
      error_r   <= error_nxt;
    end
  end

  // Frame reading store, written once per reading.
  always_ff @(posedge clk) begin
    if (rd_we) begin
      readings_r[rd_idx] <= {hi_r, rx_byte};
    end
  end

  assign readings      = readings_r;
  assign stat.done     = done;
  assign stat.version  = version_r;
  assign stat.error    = error_r;
  assign stat.cks_ok   = (sum_r == {hi_r, rx_byte});
  assign stat.end_next = (phase_r == PH_BODY) && (pos_r == POS_CKS_LO);

endmodule

// File: hw/rtl/pm_sensor_frame_parser.sv
// Parses a particulate sensor byte stream: it locks on the 0x42 0x4D start pair, collects a
// 32-byte frame and, after the frame's last byte, gives twelve results (channel 0 to 11), one
// per cycle while out_ready is high, the first one passing through the frame snapshot and then
// the output register after that byte's transaction. The byte input takes one transaction per
// cycle, also while results are draining; it stalls only on the final byte of a following frame
// if the twelve results of the previous frame have not all been moved to the output register
// yet, since a single result sequencer with one frame snapshot serves the output. With cfg_wdata
// set the result is the halved 17-bit sum of the stored and the new reading; the stored readings
// are cleared at reset. A checksum mismatch is only flagged.
module pm_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [15:0] out_reading,
  output logic [7:0]  out_sensor_version,
  output logic [7:0]  out_sensor_error,
  output logic        out_checksum_ok,
  output logic        out_last_of_frame
);
  import pmsfp_pkg::*;

  logic            avg_mode_r;
  logic            byte_fire;
  readings_t       readings;
  frame_stat_t     stat;
  readings_t       snap_r;
  logic [7:0]      snap_ver_r;
  logic [7:0]      snap_err_r;
  logic            snap_ok_r;
  readings_t       stored_r;
  logic            busy_r;
  logic [CH_W-1:0] idx_r;
  logic            advance;
  logic [16:0]     pair_sum;
  logic [15:0]     result;
  logic            out_valid_r;
  logic [3:0]      out_channel_r;
  logic [15:0]     out_reading_r;
  logic [7:0]      out_version_r;
  logic [7:0]      out_error_r;
  logic            out_ok_r;
  logic            out_last_r;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_mode_r <= 1'b0;
    end else if (cfg_we) begin
      avg_mode_r <= cfg_wdata;
    end
  end

  assign in_ready  = !(busy_r && stat.end_next);
  assign byte_fire = in_valid && in_ready;

  pmsfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(byte_fire),
    .rx_byte  (in_rx_byte),
    .readings (readings),
    .stat     (stat)
  );

  // Snapshot of a completed frame, so the parser can go on with the next one.
  always_ff @(posedge clk) begin
    if (stat.done) begin
      snap_r     <= readings;
      snap_ver_r <= stat.version;
      snap_err_r <= stat.error;
      snap_ok_r  <= stat.cks_ok;
    end
  end

  // One result per cycle while the output register can take it.
  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign pair_sum = {1'b0, stored_r[idx_r]} + {1'b0, snap_r[idx_r]};
  assign result   = avg_mode_r ? pair_sum[16:1] : snap_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      stored_r <= '0;
    end else begin
      if (stat.done) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (advance) begin
        stored_r[idx_r] <= result;
        idx_r           <= idx_r + CH_W'(1);
        if (idx_r == LAST_CH) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r <= idx_r;
      out_reading_r <= result;
      out_version_r <= snap_ver_r;
      out_error_r   <= snap_err_r;
      out_ok_r      <= snap_ok_r;
      out_last_r    <= (idx_r == LAST_CH);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_channel_r;
  assign out_reading        = out_reading_r;
  assign out_sensor_version = out_version_r;
  assign out_sensor_error   = out_error_r;
  assign out_checksum_ok    = out_ok_r;
  assign out_last_of_frame  = out_last_r;

endmodule
